@@ rtl/mssm_pkg.sv @@
`default_nettype none

package mssm_pkg;

    // Default sizing of the shared store
    localparam int MEM_DEPTH_DEF  = 32;
    localparam int MAX_STACKS_DEF = 8;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the channel fields
    localparam int CFG_W       = 4;
    localparam int STACK_NUM_W = 3;
    localparam int FIELD_W     = 32;

    // Most entries listed by one display request
    localparam int MAX_RESULTS = 32;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_SHOW = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_STACK = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // Result load request from the sequencer to the output register
    typedef struct packed {
        logic    load;
        status_t status;
        logic    from_mem;
        logic    last;
    } mssm_res_t;

endpackage

`default_nettype wire

@@ rtl/mssm_store.sv @@
`default_nettype none

module mssm_store
    import mssm_pkg::*;
#(
    parameter int DEPTH = MEM_DEPTH_DEF,
    parameter int WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one word, data valid the next cycle and held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/mssm_seq.sv @@
`default_nettype none

module mssm_seq
    import mssm_pkg::*;
#(
    parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
    parameter int MAX_STACKS = MAX_STACKS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [CFG_W-1:0]             stack_count,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   req_type,
    input  wire logic [STACK_NUM_W-1:0]       stack_number,
    input  wire logic signed [FIELD_W-1:0]    push_value,
    input  wire logic                         out_free,
    output mssm_res_t                         res,
    output logic                              wr_en,
    output logic [$clog2(MEM_DEPTH)-1:0]      wr_addr,
    output logic [DATA_WIDTH-1:0]             wr_data,
    output logic                              rd_en,
    output logic [$clog2(MEM_DEPTH)-1:0]      rd_addr
);

    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int CW  = $clog2(MEM_DEPTH + 1);
    localparam int LIM = (MAX_STACKS < MEM_DEPTH) ? MAX_STACKS : MEM_DEPTH;
    localparam int SCW = $clog2(LIM + 1);
    localparam int SIW = (LIM > 1) ? $clog2(LIM) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_EMIT  = 4'b0100,
        S_SPARE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [SCW-1:0] count_reg;
    logic [CW-1:0]  seg_reg;
    logic [CW-1:0]  fill_reg [MAX_STACKS];

    req_t                   req_reg;
    logic [STACK_NUM_W-1:0] snum_reg;
    logic                   bad_reg;
    logic                   top_stack_reg;
    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          base_reg;
    logic [DATA_WIDTH-1:0]  val_reg;
    logic [AW-1:0]          rd_addr_reg;
    logic [AW-1:0]          end_addr_reg;

    logic [CW-1:0]             seg_tab [LIM];
    logic [SCW-1:0]            cfg_cnt;
    logic [SCW-1:0]            cfg_m1;
    logic [CW-1:0]             cnt_sel;
    logic [CW+STACK_NUM_W-1:0] base_prod;
    logic [CW-1:0]             cap;
    logic [CW-1:0]             first;
    logic [CW:0]               wr_sum;
    logic [CW:0]               start_sum;
    logic [CW:0]               top_sum;
    logic                      fill_inc;
    logic                      fill_dec;
    logic                      in_fire;

    // Segment size for each stack count, settled at elaboration
    for (genvar c = 1; c <= LIM; c++)
    begin : g_seg
        localparam int SEG = MEM_DEPTH / c;
        assign seg_tab[c-1] = CW'(SEG);
    end

    // Clamp the written stack count into 1..LIM
    always_comb
    begin
        if (stack_count == '0)
        begin
            cfg_cnt = SCW'(1);
        end
        else if (int'(stack_count) > LIM)
        begin
            cfg_cnt = SCW'(LIM);
        end
        else
        begin
            cfg_cnt = SCW'(stack_count);
        end
        cfg_m1 = cfg_cnt - 1'b1;
    end

    // Pick the fill count of the addressed stack
    always_comb
    begin
        cnt_sel = '0;
        for (int i = 0; i < MAX_STACKS; i++)
        begin
            if (int'(stack_number) == i)
            begin
                cnt_sel = fill_reg[i];
            end
        end
    end

    assign base_prod = seg_reg * stack_number;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;

    // Segment bounds of the latched request
    always_comb
    begin
        cap       = top_stack_reg ? (CW'(MEM_DEPTH) - base_reg) : seg_reg;
        first     = (int'(cnt_reg) > MAX_RESULTS) ? (cnt_reg - CW'(MAX_RESULTS)) : '0;
        wr_sum    = {1'b0, base_reg} + {1'b0, cnt_reg};
        start_sum = {1'b0, base_reg} + {1'b0, first};
        top_sum   = wr_sum - 1'b1;
    end

    assign wr_addr = AW'(wr_sum);
    assign wr_data = val_reg;

    // Sequence one request: check, modify counts, stream reads to the output
    always_comb
    begin
        state_next   = state_reg;
        res          = '0;
        res.status   = ST_OK;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = AW'(rd_addr_reg + 1'b1);
        fill_inc     = 1'b0;
        fill_dec     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && req_t'(req_type) != REQ_NONE)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (bad_reg)
                    begin
                        res.load   = 1'b1;
                        res.status = ST_BAD_STACK;
                        res.last   = 1'b1;
                    end
                    else
                    begin
                        case (req_reg) inside
                            REQ_PUSH:
                            begin
                                res.load = 1'b1;
                                res.last = 1'b1;
                                if (cnt_reg >= cap)
                                begin
                                    res.status = ST_FULL;
                                end
                                else
                                begin
                                    wr_en    = 1'b1;
                                    fill_inc = 1'b1;
                                end
                            end
                            REQ_POP, REQ_SHOW:
                            begin
                                if (cnt_reg == '0)
                                begin
                                    res.load   = 1'b1;
                                    res.status = ST_EMPTY;
                                    res.last   = 1'b1;
                                end
                                else
                                begin
                                    rd_en      = 1'b1;
                                    state_next = S_EMIT;
                                    if (req_reg == REQ_POP)
                                    begin
                                        rd_addr  = AW'(top_sum);
                                        fill_dec = 1'b1;
                                    end
                                    else
                                    begin
                                        rd_addr = AW'(start_sum);
                                    end
                                end
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    res.load     = 1'b1;
                    res.from_mem = 1'b1;
                    res.last     = (rd_addr_reg == end_addr_reg);
                    if (rd_addr_reg == end_addr_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state: sequencer, stack count, segment size, fill counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= SCW'(1);
            seg_reg   <= CW'(MEM_DEPTH);
            for (int i = 0; i < MAX_STACKS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_cnt;
                seg_reg   <= seg_tab[cfg_m1[SIW-1:0]];
            end
            for (int i = 0; i < MAX_STACKS; i++)
            begin
                if (cfg_wr_en)
                begin
                    fill_reg[i] <= '0;
                end
                else if (int'(snum_reg) == i && fill_inc)
                begin
                    fill_reg[i] <= fill_reg[i] + 1'b1;
                end
                else if (int'(snum_reg) == i && fill_dec)
                begin
                    fill_reg[i] <= fill_reg[i] - 1'b1;
                end
            end
        end
    end

    // Latch the request and its segment figures on acceptance
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg       <= req_t'(req_type);
            snum_reg      <= stack_number;
            bad_reg       <= int'(stack_number) >= int'(count_reg);
            top_stack_reg <= (int'(stack_number) + 1) == int'(count_reg);
            cnt_reg       <= cnt_sel;
            base_reg      <= CW'(base_prod);
            val_reg       <= DATA_WIDTH'(push_value);
        end
        if (rd_en)
        begin
            rd_addr_reg <= rd_addr;
        end
        if (state_reg == S_CHECK)
        begin
            end_addr_reg <= AW'(top_sum);
        end
    end

endmodule

`default_nettype wire

@@ rtl/multi_stack_shared_memory.sv @@
`default_nettype none

// Channel   Handshake                Payload
// cfg       cfg_wr_en                stack_count
// in        in_valid / in_ready      req_type, stack_number, push_value
// out       out_valid / out_ready    status, data_value, last_of_run
//
// One request at a time. A push and any failed check return their result from
// the check state; a pop or a display reads the store and returns its entries
// from the emit state, paced by the single read port of the shared store.
// Reset empties every stack and sets one stack; the store itself is not
// cleared. A stalled output holds the sequencer and any display in progress.

module multi_stack_shared_memory
    import mssm_pkg::*;
#(
    parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
    parameter int MAX_STACKS = MAX_STACKS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_W-1:0]          stack_count,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                req_type,
    input  wire logic [STACK_NUM_W-1:0]    stack_number,
    input  wire logic signed [FIELD_W-1:0] push_value,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [1:0]                     status,
    output logic signed [FIELD_W-1:0]      data_value,
    output logic                           last_of_run
);

    localparam int AW = $clog2(MEM_DEPTH);

    mssm_res_t                     res;
    logic                          out_free;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [DATA_WIDTH-1:0]         wr_data;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [DATA_WIDTH-1:0]         rd_data;
    logic signed [DATA_WIDTH-1:0]  rd_sdata;

    logic                          out_valid_reg;
    logic [1:0]                    status_reg;
    logic signed [FIELD_W-1:0]     data_reg;
    logic                          last_reg;

    mssm_seq #(
        .MEM_DEPTH  (MEM_DEPTH),
        .MAX_STACKS (MAX_STACKS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .stack_count  (stack_count),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .stack_number (stack_number),
        .push_value   (push_value),
        .out_free     (out_free),
        .res          (res),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr)
    );

    mssm_store #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_sdata = rd_data;
    assign out_free = !out_valid_reg || out_ready;

    // Output beat valid: set on load, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output beat payload, sign-extended from the stored width
    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            status_reg <= res.status;
            data_reg   <= res.from_mem ? FIELD_W'(rd_sdata) : '0;
            last_reg   <= res.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign data_value  = data_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

@@ tb/multi_stack_shared_memory_tb.sv @@
`timescale 1ns / 1ps

module multi_stack_shared_memory_tb;
    import mssm_pkg::*;

    localparam int DEPTH  = MEM_DEPTH_DEF;
    localparam int STACKS = MAX_STACKS_DEF;
    localparam int DRAIN_CYCLES = 48;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [1:0]         st;
        logic signed [31:0] data;
        logic               last;
    } stack_result_t;

    // Mirror of the stacks: predicts every beat the block should return
    class stack_mirror;
        logic [31:0]   words [DEPTH];
        int unsigned   fill [STACKS];
        int unsigned   seg_size;
        int unsigned   count_now;
        stack_result_t pending_results [$];
        int            errors;
        int            n_requests;
        int            n_results;

        function new();
            errors     = 0;
            n_requests = 0;
            n_results  = 0;
            foreach (words[i]) words[i] = '0;
            set_count(1);
        endfunction

        // Saturate the count, resize segments and empty every stack
        function void set_count(int unsigned value);
            int unsigned c;
            int unsigned lim;
            lim = (STACKS < DEPTH) ? STACKS : DEPTH;
            c = value;
            if (c < 1) c = 1;
            if (c > lim) c = lim;
            count_now = c;
            seg_size  = DEPTH / c;
            foreach (fill[i]) fill[i] = 0;
        endfunction

        function int unsigned capacity(int unsigned s);
            if (s + 1 == count_now) return DEPTH - seg_size * s;
            return seg_size;
        endfunction

        function void push_expect(logic [1:0] st, logic [31:0] data, logic last);
            stack_result_t r;
            r.st   = st;
            r.data = data;
            r.last = last;
            pending_results.push_back(r);
        endfunction

        // Apply one accepted request and queue its results
        function void take_request(logic [1:0] rq, logic [2:0] sn, logic [31:0] pv);
            int unsigned s;
            int unsigned base;
            int unsigned cnt;
            int unsigned first;
            if (rq == REQ_NONE) return;
            n_requests++;
            s = 32'(sn);
            if (s >= count_now || s >= STACKS) begin
                push_expect(ST_BAD_STACK, '0, 1'b1);
                return;
            end
            base = seg_size * s;
            cnt  = fill[s];
            if (rq == REQ_PUSH) begin
                if (cnt >= capacity(s)) begin
                    push_expect(ST_FULL, '0, 1'b1);
                    return;
                end
                if (base + cnt < DEPTH) words[base + cnt] = pv;
                fill[s] = cnt + 1;
                push_expect(ST_OK, '0, 1'b1);
                return;
            end
            if (cnt == 0) begin
                push_expect(ST_EMPTY, '0, 1'b1);
                return;
            end
            if (rq == REQ_POP) begin
                push_expect(ST_OK, words[base + cnt - 1], 1'b1);
                fill[s] = cnt - 1;
                return;
            end
            // List from bottom to top, top MAX_RESULTS entries at most
            first = (cnt > MAX_RESULTS) ? cnt - MAX_RESULTS : 0;
            for (int unsigned j = first; j < cnt; j++)
                push_expect(ST_OK, words[base + j], (j + 1 == cnt));
        endfunction

        // Compare one returned beat with the oldest expectation
        function void match_result(logic [1:0] st, logic [31:0] data, logic last);
            stack_result_t r;
            n_results++;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: status %0d data %0d last %0d",
                       st, $signed(data), last);
                errors++;
                return;
            end
            r = pending_results.pop_front();
            if (st !== r.st) begin
                $error("status: expected %0d, got %0d", r.st, st);
                errors++;
            end
            if (data !== r.data) begin
                $error("data_value: expected %0d, got %0d", $signed(r.data), $signed(data));
                errors++;
            end
            if (last !== r.last) begin
                $error("last_of_run: expected %0d, got %0d", r.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_W-1:0]          stack_count;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                req_type;
    logic [STACK_NUM_W-1:0]    stack_number;
    logic signed [FIELD_W-1:0] push_value;
    logic                      out_valid;
    logic                      out_ready;
    logic [1:0]                status;
    logic signed [FIELD_W-1:0] data_value;
    logic                      last_of_run;

    logic hold_req;
    int   n_settings;

    stack_mirror mirror = new();

    multi_stack_shared_memory dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .stack_count  (stack_count),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .stack_number (stack_number),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .data_value   (data_value),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #50_000_000;
        $display("FAIL multi_stack_shared_memory");
        $finish;
    end

    // Most gaps short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Check output beats and record accepted requests
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                mirror.match_result(status, data_value, last_of_run);
            if (in_valid && in_ready)
                mirror.take_request(req_type, stack_number, push_value);
        end
    end

    // Receiver: random ready bursts, and one long hold-off on request
    initial
    begin
        int n_on;
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        @(negedge clk);
        forever begin
            if (hold_req && !hold_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else begin
                n_on = $urandom_range(1, 20);
                out_ready <= 1'b1;
                repeat (n_on) @(negedge clk);
                gap = pick_gap();
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
    end

    // Offer one request beat and hold it until accepted; called at a falling edge
    task automatic send_req(req_t rq, logic [2:0] sn, logic [31:0] pv, bit gaps);
        int gap;
        req_type     <= rq;
        stack_number <= sn;
        push_value   <= pv;
        in_valid     <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        gap = gaps ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drop valid and wait for every expected beat, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (mirror.pending_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_count(logic [CFG_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        stack_count <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        mirror.set_count(32'(value));
        n_settings++;
    endtask

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 32'h7fff_ffff;
        if (r < 8) return 32'h8000_0000;
        if (r < 10) return 32'h0000_0000;
        if (r < 12) return 32'hffff_ffff;
        return $urandom;
    endfunction

    // Random mix, mostly aimed at configured stacks
    task automatic random_requests(int n, bit gaps);
        int   done;
        int   r;
        req_t rq;
        logic [2:0] sn;
        done = 0;
        while (done < n) begin
            r = $urandom_range(0, 99);
            if (r < 45) rq = REQ_PUSH;
            else if (r < 70) rq = REQ_POP;
            else if (r < 85) rq = REQ_SHOW;
            else if (r < 90) rq = REQ_NONE;
            else rq = req_t'($urandom_range(0, 2));
            if ($urandom_range(0, 99) < 85)
                sn = 3'($urandom_range(0, mirror.count_now - 1));
            else
                sn = 3'($urandom_range(0, 7));
            send_req(rq, sn, pick_value(), gaps);
            if (rq != REQ_NONE) done++;
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] settings [10];
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        stack_count  = '0;
        in_valid     = 1'b0;
        req_type     = REQ_PUSH;
        stack_number = '0;
        push_value   = '0;
        hold_req     = 1'b0;
        n_settings   = 0;
        settings = '{4'd15, 4'd3, 4'd0, 4'd5, 4'd2, 4'd7, 4'd1, 4'd4, 4'd6, 4'd8};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // One stack after reset: extremes, pops, displays, empty and invalid
        send_req(REQ_PUSH, 3'd0, 32'h7fff_ffff, 1'b1);
        send_req(REQ_PUSH, 3'd0, 32'h8000_0000, 1'b1);
        send_req(REQ_PUSH, 3'd0, 32'h0000_0000, 1'b1);
        send_req(REQ_PUSH, 3'd0, 32'hffff_ffff, 1'b1);
        send_req(REQ_SHOW, 3'd0, 32'h0, 1'b1);
        send_req(REQ_POP,  3'd0, 32'h0, 1'b1);
        send_req(REQ_POP,  3'd0, 32'h0, 1'b1);
        send_req(REQ_SHOW, 3'd0, 32'h0, 1'b1);
        send_req(REQ_POP,  3'd0, 32'h0, 1'b1);
        send_req(REQ_POP,  3'd0, 32'h0, 1'b1);
        send_req(REQ_POP,  3'd0, 32'h0, 1'b1);
        send_req(REQ_SHOW, 3'd0, 32'h0, 1'b1);
        send_req(REQ_PUSH, 3'd7, 32'h1234_5678, 1'b1);
        send_req(REQ_POP,  3'd1, 32'h0, 1'b1);
        send_req(REQ_SHOW, 3'd4, 32'h0, 1'b1);
        // Unused request type leaves no trace
        send_req(REQ_NONE, 3'd0, 32'h5a5a_5a5a, 1'b1);
        send_req(REQ_SHOW, 3'd0, 32'h0, 1'b1);

        // Eight stacks: fill the last one past its segment
        write_count(4'd8);
        send_req(REQ_PUSH, 3'd7, 32'h0000_0001, 1'b1);
        send_req(REQ_PUSH, 3'd7, 32'h8000_0000, 1'b1);
        send_req(REQ_PUSH, 3'd7, 32'h7fff_ffff, 1'b1);
        send_req(REQ_PUSH, 3'd7, 32'hdead_beef, 1'b1);
        send_req(REQ_PUSH, 3'd7, 32'h0000_0002, 1'b1);
        send_req(REQ_SHOW, 3'd7, 32'h0, 1'b1);
        send_req(REQ_POP,  3'd7, 32'h0, 1'b1);
        send_req(REQ_SHOW, 3'd6, 32'h0, 1'b1);

        // Random phases over several stack counts
        foreach (settings[p]) begin
            write_count(settings[p]);
            if (settings[p] == 4'd0) begin
                // One stack of the whole store: fill, overflow, long display
                for (int i = 0; i < DEPTH; i++)
                    send_req(REQ_PUSH, 3'd0, pick_value(), p[0]);
                send_req(REQ_PUSH, 3'd0, pick_value(), 1'b1);
                send_req(REQ_SHOW, 3'd0, 32'h0, 1'b1);
            end
            if (settings[p] == 4'd3) begin
                // Stall the output while requests keep coming
                hold_req <= 1'b1;
                random_requests(16, 1'b0);
            end
            random_requests(18, p[0]);
        end

        // Wait for the tail, then allow for any stray beats
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests and %0d result beats over %0d stack-count settings,",
                 mirror.n_requests, mirror.n_results, n_settings);
        $display("with full, empty, invalid-stack, ignored and full-depth display cases.");
        if (mirror.errors == 0 && mirror.pending_results.size() == 0)
            $display("PASS multi_stack_shared_memory");
        else
            $display("FAIL multi_stack_shared_memory");
        $finish;
    end

endmodule
